// ===== rtl/core/owrr_pkg.sv =====
package owrr_pkg;

   localparam int MAX_SLOTS_DEFAULT      = 256;
   localparam int SLOT_MAX_BYTES_DEFAULT = 8;
   localparam int NUM_READERS_DEFAULT    = 4;

   localparam int ACTION_W    = 2;
   localparam int READER_W    = 2;
   localparam int PAYLOAD_W   = 64;
   localparam int LEN_W       = 8;
   localparam int COUNT_W     = 64;
   localparam int COPIED_W    = 4;
   localparam int AVAIL_W     = 9;
   localparam int SLOTS_CFG_W = 9;
   localparam int BYTES_CFG_W = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   localparam logic [SLOTS_CFG_W-1:0] SLOTS_CFG_RESET = 9'd256;
   localparam logic [BYTES_CFG_W-1:0] BYTES_CFG_RESET = 4'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_BYTES   = 4'd1;

   localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_JOIN = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic update;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/overwrite_ring_multi_reader.sv =====
// Each transfer in passes through capture, lag compare, counter and slot
// memory update, then result load into the output registers; a new item is
// taken only once the controller is back in idle.
// A result waiting on a stalled output holds the controller in its last step.
// Synchronous active-high reset clears the counters and the output valid and
// restores the ring size and slot size; slot contents are not cleared.
module overwrite_ring_multi_reader #(
   parameter int MAX_SLOTS      = owrr_pkg::MAX_SLOTS_DEFAULT,
   parameter int SLOT_MAX_BYTES = owrr_pkg::SLOT_MAX_BYTES_DEFAULT,
   parameter int NUM_READERS    = owrr_pkg::NUM_READERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [owrr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [owrr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [owrr_pkg::ACTION_W-1:0]       req_action,
   input  logic [owrr_pkg::READER_W-1:0]       req_reader,
   input  logic [owrr_pkg::PAYLOAD_W-1:0]      req_payload,
   input  logic [owrr_pkg::LEN_W-1:0]          req_payload_len,
   input  logic [owrr_pkg::LEN_W-1:0]          req_want_len,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [owrr_pkg::PAYLOAD_W-1:0]      rsp_read_bytes,
   output logic [owrr_pkg::COPIED_W-1:0]       rsp_copied_len,
   output logic [owrr_pkg::AVAIL_W-1:0]        rsp_avail_count,
   output logic                                rsp_skipped_flag,
   output logic                                rsp_truncated_flag
);
   import owrr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   owrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   owrr_datapath #(
      .MAX_SLOTS      (MAX_SLOTS),
      .SLOT_MAX_BYTES (SLOT_MAX_BYTES),
      .NUM_READERS    (NUM_READERS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_action         (req_action),
      .req_reader         (req_reader),
      .req_payload        (req_payload),
      .req_payload_len    (req_payload_len),
      .req_want_len       (req_want_len),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_bytes     (rsp_read_bytes),
      .rsp_copied_len     (rsp_copied_len),
      .rsp_avail_count    (rsp_avail_count),
      .rsp_skipped_flag   (rsp_skipped_flag),
      .rsp_truncated_flag (rsp_truncated_flag)
   );

endmodule

// ===== rtl/core/owrr_ctrl.sv =====
module owrr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  owrr_pkg::dp_status_type status,
   output owrr_pkg::dp_cmd_type    cmd
);
   import owrr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.calc    = (state_ff == ST_CALC);
      cmd.update  = (state_ff == ST_UPDATE);
      cmd.finish  = (state_ff == ST_FINISH) && status.out_free;
   end

endmodule

// ===== rtl/core/owrr_datapath.sv =====
module owrr_datapath #(
   parameter int MAX_SLOTS      = owrr_pkg::MAX_SLOTS_DEFAULT,
   parameter int SLOT_MAX_BYTES = owrr_pkg::SLOT_MAX_BYTES_DEFAULT,
   parameter int NUM_READERS    = owrr_pkg::NUM_READERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  owrr_pkg::dp_cmd_type                 cmd,
   output owrr_pkg::dp_status_type              status,
   input  logic                                csr_wr_en,
   input  logic [owrr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [owrr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [owrr_pkg::ACTION_W-1:0]       req_action,
   input  logic [owrr_pkg::READER_W-1:0]       req_reader,
   input  logic [owrr_pkg::PAYLOAD_W-1:0]      req_payload,
   input  logic [owrr_pkg::LEN_W-1:0]          req_payload_len,
   input  logic [owrr_pkg::LEN_W-1:0]          req_want_len,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [owrr_pkg::PAYLOAD_W-1:0]      rsp_read_bytes,
   output logic [owrr_pkg::COPIED_W-1:0]       rsp_copied_len,
   output logic [owrr_pkg::AVAIL_W-1:0]        rsp_avail_count,
   output logic                                rsp_skipped_flag,
   output logic                                rsp_truncated_flag
);
   import owrr_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int RING_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = (RING_W > SLOTS_CFG_W) ? RING_W : SLOTS_CFG_W;
   localparam int RD_W   = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
   localparam int DATA_W = 8 * SLOT_MAX_BYTES;

   function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [COPIED_W-1:0] n);
      logic [PAYLOAD_W-1:0] m;
      m = '0;
      for (int i = 0; i < PAYLOAD_W / 8; i++) begin
         if (COPIED_W'(i) < n) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   logic [SLOTS_CFG_W-1:0] slots_cfg_ff;
   logic [BYTES_CFG_W-1:0] bytes_cfg_ff;

   logic [ACTION_W-1:0]  action_ff;
   logic [READER_W-1:0]  reader_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [LEN_W-1:0]     plen_ff;
   logic [LEN_W-1:0]     want_ff;

   logic [COUNT_W-1:0] wcount_ff;
   logic [COUNT_W-1:0] wcount_in;
   logic [SLOT_W-1:0]  wslot_ff;
   logic [SLOT_W-1:0]  wslot_in;
   logic [COUNT_W-1:0] rcount_ff [NUM_READERS];
   logic [COUNT_W-1:0] rcount_in [NUM_READERS];
   logic [SLOT_W-1:0]  rslot_ff  [NUM_READERS];
   logic [SLOT_W-1:0]  rslot_in  [NUM_READERS];

   logic [COUNT_W-1:0] lag_ff;
   logic               behind_ff;
   logic               skipped_ff;
   logic               skipped_in;
   logic [COPIED_W-1:0] copied_ff;
   logic [COPIED_W-1:0] copied_in;
   logic               trunc_ff;
   logic               trunc_in;

   logic [DATA_W-1:0] slot_mem [MAX_SLOTS];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_we;
   logic              mem_re;
   logic [SLOT_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wdata;

   logic                   rsp_valid_ff;
   logic [PAYLOAD_W-1:0]   rsp_read_bytes_ff;
   logic [COPIED_W-1:0]    rsp_copied_len_ff;
   logic [AVAIL_W-1:0]     rsp_avail_count_ff;
   logic                   rsp_skipped_ff;
   logic                   rsp_truncated_ff;

   logic [CMP_W-1:0]       slots_ext;
   logic [RING_W-1:0]      ring_n;
   logic [BYTES_CFG_W-1:0] slot_b;
   logic [RD_W-1:0]        rd_sel;
   logic                   r_valid;
   logic [COUNT_W-1:0]     rcount_sel;
   logic [SLOT_W-1:0]      rslot_sel;
   logic                   sub_borrow;
   logic [COUNT_W-1:0]     sub_diff;
   logic                   has_unread;
   logic [RING_W-1:0]      avail;
   logic                   push_trunc;
   logic [COPIED_W-1:0]    push_keep;
   logic                   do_skip;
   logic [SLOT_W-1:0]      read_pos;

   function automatic logic [SLOT_W-1:0] next_pos(input logic [SLOT_W-1:0] p,
                                                  input logic [RING_W-1:0] n);
      logic [RING_W-1:0] q;
      q = RING_W'(p) + RING_W'(1);
      if (q >= n) begin
         return '0;
      end
      return SLOT_W'(q);
   endfunction

   always_comb begin
      slots_ext = CMP_W'(slots_cfg_ff);
      if (slots_cfg_ff == '0) begin
         ring_n = RING_W'(1);
      end else if (slots_ext > CMP_W'(MAX_SLOTS)) begin
         ring_n = RING_W'(MAX_SLOTS);
      end else begin
         ring_n = RING_W'(slots_ext);
      end

      if (bytes_cfg_ff == '0) begin
         slot_b = BYTES_CFG_W'(1);
      end else if (bytes_cfg_ff > BYTES_CFG_W'(SLOT_MAX_BYTES)) begin
         slot_b = BYTES_CFG_W'(SLOT_MAX_BYTES);
      end else begin
         slot_b = bytes_cfg_ff;
      end
   end

   assign rd_sel     = RD_W'(reader_ff);
   assign r_valid    = (32'(reader_ff) < 32'(NUM_READERS));
   assign rcount_sel = r_valid ? rcount_ff[rd_sel] : '0;
   assign rslot_sel  = r_valid ? rslot_ff[rd_sel] : '0;

   // One shared subtractor: it gives the lag before a read and the
   // available count once the item has updated the counters.
   assign {sub_borrow, sub_diff} = {1'b0, wcount_ff} - {1'b0, rcount_sel};
   assign has_unread = r_valid && !sub_borrow && (sub_diff != '0);

   always_comb begin
      if (!has_unread) begin
         avail = '0;
      end else if (sub_diff > COUNT_W'(ring_n)) begin
         avail = ring_n;
      end else begin
         avail = RING_W'(sub_diff);
      end
   end

   assign push_trunc = (plen_ff > LEN_W'(slot_b));
   assign push_keep  = push_trunc ? slot_b : plen_ff[COPIED_W-1:0];
   assign do_skip    = behind_ff && (lag_ff > COUNT_W'(ring_n));
   assign read_pos   = do_skip ? wslot_ff : rslot_sel;

   always_comb begin
      wcount_in  = wcount_ff;
      wslot_in   = wslot_ff;
      rcount_in  = rcount_ff;
      rslot_in   = rslot_ff;
      skipped_in = 1'b0;
      copied_in  = '0;
      trunc_in   = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = wslot_ff;
      mem_wdata  = DATA_W'(payload_ff & byte_mask(push_keep));
      unique case (action_ff)
         ACT_PUSH: begin
            if (plen_ff != '0) begin
               mem_we    = 1'b1;
               trunc_in  = push_trunc;
               wslot_in  = next_pos(wslot_ff, ring_n);
               wcount_in = wcount_ff + COUNT_W'(1);
            end
         end
         ACT_READ: begin
            mem_addr = read_pos;
            if (behind_ff) begin
               mem_re     = 1'b1;
               skipped_in = do_skip;
               copied_in  = (want_ff < LEN_W'(slot_b)) ? want_ff[COPIED_W-1:0] : slot_b;
               rslot_in[rd_sel] = next_pos(read_pos, ring_n);
               if (do_skip) begin
                  rcount_in[rd_sel] = wcount_ff - (COUNT_W'(ring_n) - COUNT_W'(1));
               end else begin
                  rcount_in[rd_sel] = rcount_sel + COUNT_W'(1);
               end
            end
         end
         ACT_JOIN: begin
            if (r_valid) begin
               rcount_in[rd_sel] = wcount_ff;
               rslot_in[rd_sel]  = wslot_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_cfg_ff <= SLOTS_CFG_RESET;
         bytes_cfg_ff <= BYTES_CFG_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SLOTS_IN_USE) begin
            slots_cfg_ff <= csr_wdata[SLOTS_CFG_W-1:0];
         end else if (csr_index == CSR_SLOT_BYTES) begin
            bytes_cfg_ff <= csr_wdata[BYTES_CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_action;
         reader_ff  <= req_reader;
         payload_ff <= req_payload;
         plen_ff    <= req_payload_len;
         want_ff    <= req_want_len;
      end
      if (cmd.calc) begin
         lag_ff    <= sub_diff;
         behind_ff <= has_unread;
      end
      if (cmd.update) begin
         skipped_ff <= skipped_in;
         copied_ff  <= copied_in;
         trunc_ff   <= trunc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff <= '0;
         wslot_ff  <= '0;
         for (int i = 0; i < NUM_READERS; i++) begin
            rcount_ff[i] <= '0;
            rslot_ff[i]  <= '0;
         end
      end else if (cmd.update) begin
         wcount_ff <= wcount_in;
         wslot_ff  <= wslot_in;
         rcount_ff <= rcount_in;
         rslot_ff  <= rslot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && mem_we) begin
         slot_mem[mem_addr] <= mem_wdata;
      end
      if (cmd.update && mem_re) begin
         rd_data_ff <= slot_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_read_bytes_ff  <= PAYLOAD_W'(rd_data_ff) & byte_mask(copied_ff);
         rsp_copied_len_ff  <= copied_ff;
         rsp_avail_count_ff <= AVAIL_W'(avail);
         rsp_skipped_ff     <= skipped_ff;
         rsp_truncated_ff   <= trunc_ff;
      end
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_bytes     = rsp_read_bytes_ff;
   assign rsp_copied_len     = rsp_copied_len_ff;
   assign rsp_avail_count    = rsp_avail_count_ff;
   assign rsp_skipped_flag   = rsp_skipped_ff;
   assign rsp_truncated_flag = rsp_truncated_ff;

endmodule

// ===== test/overwrite_ring_multi_reader_checker.sv =====
module overwrite_ring_multi_reader_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [owrr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [owrr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [owrr_pkg::ACTION_W-1:0]       req_action,
   input  logic [owrr_pkg::READER_W-1:0]       req_reader,
   input  logic [owrr_pkg::PAYLOAD_W-1:0]      req_payload,
   input  logic [owrr_pkg::LEN_W-1:0]          req_payload_len,
   input  logic [owrr_pkg::LEN_W-1:0]          req_want_len,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [owrr_pkg::PAYLOAD_W-1:0]      rsp_read_bytes,
   input  logic [owrr_pkg::COPIED_W-1:0]       rsp_copied_len,
   input  logic [owrr_pkg::AVAIL_W-1:0]        rsp_avail_count,
   input  logic                                rsp_skipped_flag,
   input  logic                                rsp_truncated_flag,
   output int                                  mismatches,
   output int                                  pending_results
);
   import owrr_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] data;
      logic [COPIED_W-1:0]  copied;
      logic [AVAIL_W-1:0]   avail;
      logic                 skipped;
      logic                 truncated;
   } ring_result_type;

   ring_result_type expected_q[$];
   ring_result_type observed;
   ring_result_type oldest;

   logic [SLOTS_CFG_W-1:0] ring_cfg;
   logic [BYTES_CFG_W-1:0] bytes_cfg;
   logic [COUNT_W-1:0]     pushed_total;
   int unsigned            head_pos;
   logic [COUNT_W-1:0]     read_total [NUM_READERS_DEFAULT];
   int unsigned            read_pos [NUM_READERS_DEFAULT];
   logic [PAYLOAD_W-1:0]   slot_mem [MAX_SLOTS_DEFAULT];

   function automatic int unsigned ring_len();
      if (ring_cfg == 0) return 1;
      if (32'(ring_cfg) > MAX_SLOTS_DEFAULT) return MAX_SLOTS_DEFAULT;
      return 32'(ring_cfg);
   endfunction

   function automatic int unsigned slot_width();
      if (bytes_cfg == 0) return 1;
      if (32'(bytes_cfg) > SLOT_MAX_BYTES_DEFAULT) return SLOT_MAX_BYTES_DEFAULT;
      return 32'(bytes_cfg);
   endfunction

   function automatic logic [PAYLOAD_W-1:0] byte_keep(input int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function automatic int unsigned step_pos(input int unsigned p);
      if (p + 1 >= ring_len()) return 0;
      return p + 1;
   endfunction

   function automatic logic [AVAIL_W-1:0] unread_slots(input int unsigned r);
      logic [COUNT_W-1:0] diff;
      if (read_total[r] >= pushed_total) return '0;
      diff = pushed_total - read_total[r];
      if (diff > COUNT_W'(ring_len())) diff = COUNT_W'(ring_len());
      return diff[AVAIL_W-1:0];
   endfunction

   function automatic ring_result_type apply_request(
      input logic [ACTION_W-1:0]  action,
      input logic [READER_W-1:0]  who,
      input logic [PAYLOAD_W-1:0] bytes,
      input logic [LEN_W-1:0]     blen,
      input logic [LEN_W-1:0]     room
   );
      ring_result_type res;
      int unsigned width;
      int unsigned keep;
      int unsigned take;
      int unsigned p;
      res = '0;
      width = slot_width();
      case (action)
         ACT_PUSH: begin
            if (blen != 0) begin
               keep = 32'(blen);
               if (32'(blen) > width) begin
                  keep = width;
                  res.truncated = 1'b1;
               end
               slot_mem[head_pos] = bytes & byte_keep(keep);
               head_pos = step_pos(head_pos);
               pushed_total = pushed_total + COUNT_W'(1);
            end
         end
         ACT_READ: begin
            if (read_total[who] < pushed_total) begin
               // A reader more than one ring behind restarts at the oldest held slot.
               if (pushed_total - read_total[who] > COUNT_W'(ring_len())) begin
                  read_total[who] = pushed_total - COUNT_W'(ring_len());
                  read_pos[who] = head_pos;
                  res.skipped = 1'b1;
               end
               take = (32'(room) < width) ? 32'(room) : width;
               p = read_pos[who];
               res.data = slot_mem[p] & byte_keep(take);
               res.copied = take[COPIED_W-1:0];
               read_pos[who] = step_pos(p);
               read_total[who] = read_total[who] + COUNT_W'(1);
            end
         end
         ACT_JOIN: begin
            read_total[who] = pushed_total;
            read_pos[who] = head_pos;
         end
         default: begin
         end
      endcase
      res.avail = unread_slots(32'(who));
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ring_cfg = SLOTS_CFG_RESET;
         bytes_cfg = BYTES_CFG_RESET;
         pushed_total = '0;
         head_pos = 0;
         for (int i = 0; i < NUM_READERS_DEFAULT; i++) begin
            read_total[i] = '0;
            read_pos[i] = 0;
         end
         expected_q.delete();
         mismatches = 0;
         pending_results = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SLOTS_IN_USE: ring_cfg = csr_wdata[SLOTS_CFG_W-1:0];
               CSR_SLOT_BYTES: bytes_cfg = csr_wdata[BYTES_CFG_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            observed = {rsp_read_bytes, rsp_copied_len, rsp_avail_count,
                        rsp_skipped_flag, rsp_truncated_flag};
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result transfer: data=%h copied=%0d avail=%0d",
                           observed.data, observed.copied, observed.avail);
            end else begin
               oldest = expected_q.pop_front();
               if (observed.data !== oldest.data || observed.copied !== oldest.copied ||
                   observed.avail !== oldest.avail || observed.skipped !== oldest.skipped ||
                   observed.truncated !== oldest.truncated) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"result mismatch: expected data=%h copied=%0d avail=%0d ",
                               "skip=%0b trunc=%0b, got data=%h copied=%0d avail=%0d ",
                               "skip=%0b trunc=%0b"},
                              oldest.data, oldest.copied, oldest.avail, oldest.skipped,
                              oldest.truncated, observed.data, observed.copied,
                              observed.avail, observed.skipped, observed.truncated);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(apply_request(req_action, req_reader, req_payload,
                                               req_payload_len, req_want_len));
         pending_results = expected_q.size();
      end
   end

endmodule

// ===== test/overwrite_ring_multi_reader_tb.sv =====
module overwrite_ring_multi_reader_tb;
   import owrr_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int STALL_PCT      = 22;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int FILL_PUSHES    = MAX_SLOTS_DEFAULT;
   localparam int PHASE_ITEMS    = 35;
   localparam int PHASES         = 8;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   logic [ACTION_W-1:0]    req_action;
   logic [READER_W-1:0]    req_reader;
   logic [PAYLOAD_W-1:0]   req_payload;
   logic [LEN_W-1:0]       req_payload_len;
   logic [LEN_W-1:0]       req_want_len;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PAYLOAD_W-1:0]   rsp_read_bytes;
   logic [COPIED_W-1:0]    rsp_copied_len;
   logic [AVAIL_W-1:0]     rsp_avail_count;
   logic                   rsp_skipped_flag;
   logic                   rsp_truncated_flag;

   int mismatches;
   int pending_results;
   bit steady_run;
   bit hold_request;
   int idle_cycles;
   int pushes_stored;
   int action_seen [4];

   overwrite_ring_multi_reader uut (.*);

   overwrite_ring_multi_reader_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls at random, except during the quiet phase and a single
   // long hold-off that lets the block fill up and stall its input.
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !steady_run && ($urandom_range(99) < STALL_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [ACTION_W-1:0] action,
                            input logic [READER_W-1:0] who,
                            input logic [PAYLOAD_W-1:0] bytes,
                            input logic [LEN_W-1:0] blen,
                            input logic [LEN_W-1:0] room);
      while (!steady_run && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_reader <= who;
      req_payload <= bytes;
      req_payload_len <= blen;
      req_want_len <= room;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (action == ACT_PUSH && blen != 0) pushes_stored++;
      action_seen[action]++;
      @(negedge clock);
   endtask

   function automatic logic [LEN_W-1:0] random_len();
      case ($urandom_range(9))
         0: return '0;
         1: return LEN_W'($urandom_range(9, 255));
         default: return LEN_W'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic random_item(input int push_pct);
      int unsigned pick;
      logic [ACTION_W-1:0] action;
      pick = $urandom_range(99);
      if (pick < push_pct) action = ACT_PUSH;
      else if (pick < 90) action = ACT_READ;
      else if (pick < 97) action = ACT_JOIN;
      else action = ACT_UNUSED;
      send_item(action, READER_W'($urandom_range(3)), {$urandom, $urandom}, random_len(),
                random_len());
   endtask

   task automatic end_phase();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic set_ring(input logic [CSR_DATA_W-1:0] slots,
                           input logic [CSR_DATA_W-1:0] width);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SLOTS_IN_USE;
      csr_wdata <= slots;
      @(negedge clock);
      csr_index <= CSR_SLOT_BYTES;
      csr_wdata <= width;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned ring_plan [PHASES];
      int unsigned width_plan [PHASES];
      ring_plan = '{1, 2, 5, 256, 0, 300, 17, 3};
      width_plan = '{1, 3, 8, 1, 0, 15, 5, 2};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_action = '0;
      req_reader = '0;
      req_payload = '0;
      req_payload_len = '0;
      req_want_len = '0;
      steady_run = 1'b0;
      hold_request = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default ring: caught-up reads, zero and oversized pushes, short copies,
      // joins, the unused action code and every reader.
      send_item(ACT_READ, 0, '0, 8'd0, 8'd8);
      send_item(ACT_PUSH, 1, '1, 8'd0, 8'd0);
      send_item(ACT_PUSH, 0, '1, 8'd8, 8'd0);
      send_item(ACT_PUSH, 3, {$urandom, $urandom}, 8'd255, 8'd255);
      send_item(ACT_PUSH, 0, '1, 8'd1, 8'd0);
      send_item(ACT_PUSH, 0, 64'h0123_4567_89ab_cdef, 8'd3, 8'd0);
      send_item(ACT_READ, 0, '0, 8'd0, 8'd255);
      send_item(ACT_READ, 0, '1, 8'd255, 8'd0);
      send_item(ACT_READ, 0, '0, 8'd0, 8'd1);
      send_item(ACT_READ, 0, '0, 8'd0, 8'd5);
      send_item(ACT_READ, 0, '0, 8'd0, 8'd8);
      send_item(ACT_JOIN, 1, '0, 8'd0, 8'd0);
      send_item(ACT_READ, 1, '0, 8'd0, 8'd8);
      send_item(ACT_UNUSED, 2, '1, 8'd255, 8'd255);
      send_item(ACT_READ, 3, '0, 8'd0, 8'd8);
      send_item(ACT_READ, 2, '0, 8'd0, 8'd7);
      send_item(ACT_PUSH, 2, '0, 8'd8, 8'd0);
      send_item(ACT_JOIN, 3, '0, 8'd0, 8'd0);
      send_item(ACT_READ, 3, '0, 8'd0, 8'd8);
      send_item(ACT_READ, 1, '0, 8'd0, 8'd8);

      // Every slot is written before the ring size first changes, so no read
      // can ever land on a slot that holds nothing yet.
      while (pushes_stored < FILL_PUSHES) random_item(70);
      end_phase();

      for (int phase = 0; phase < PHASES; phase++) begin
         set_ring(CSR_DATA_W'(ring_plan[phase]), CSR_DATA_W'(width_plan[phase]));
         steady_run = (phase == 2);
         if (phase == 4) hold_request = 1'b1;
         repeat (PHASE_ITEMS) random_item(55);
         end_phase();
      end
      steady_run = 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d pushes (%0d stored), %0d reads, %0d joins, %0d unused codes",
               action_seen[ACT_PUSH], pushes_stored, action_seen[ACT_READ],
               action_seen[ACT_JOIN], action_seen[ACT_UNUSED]);
      $display("across %0d ring and slot settings, with one %0d-cycle receiver hold-off",
               PHASES + 1, HOLD_CYCLES);
      if (mismatches == 0 && pending_results == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
